FILE: src/tcp_syn_mss_clamper_defines.svh
// Assertion macros shared by the MSS clamp files.
`ifndef TCP_SYN_MSS_CLAMPER_DEFINES_SVH
`define TCP_SYN_MSS_CLAMPER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/tsmc_pkg.sv
// Types and constants for the TCP SYN MSS clamp.
`timescale 1ns / 1ps
package tsmc_pkg;
  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_CLAMPED = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_MTU      = 2'd1;
  localparam logic [1:0] CFG_OVERHEAD = 2'd2;

  localparam int unsigned MinMtu = 576;
  localparam logic [16:0] MinMss = 17'd536;
  localparam logic [7:0]  OptMss = 8'h02;

  // Per-packet summary handed from the parser to the finisher.
  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  l3;
    logic [5:0]  ihl;
    logic [6:0]  doff;
    logic [2:0]  verdict;
    logic [6:0]  opt_pos;
    logic [15:0] mss;
    logic        mss_found;
    logic [15:0] cks;
  } pkt_sum_t;
endpackage

FILE: src/tsmc_parser.sv
// Front end: byte-wise header parse and TCP option walk.
`timescale 1ns / 1ps
module tsmc_parser import tsmc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  pkt_byte_i,
  input  logic [7:0]  l3_offset_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        sum_valid_o,
  output pkt_sum_t    sum_o
);
  logic [15:0] pos_q, pos_d;
  logic [7:0]  l3_q, l3_d;
  logic [5:0]  ihl_q, ihl_d;
  logic [6:0]  doff_q, doff_d;
  logic [2:0]  ver_q, ver_d;
  logic [6:0]  nop_q, nop_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  olen_q, olen_d;
  logic        stop_q, stop_d;
  logic [15:0] mss_q, mss_d;
  logic        mf_q, mf_d;
  logic [15:0] cks_q, cks_d;

  logic [15:0] p, r, t;
  logic [5:0]  ihl_s;
  logic [6:0]  doff_s, nop_s;
  logic [7:0]  kind_s, olen_s;
  logic [2:0]  ver_s;
  logic        stop_s, mf_s;
  logic [15:0] mss_s, cks_s;
  logic [8:0]  nb;

  always_comb begin
    // start values: restart on first_byte
    p      = first_byte_i ? 16'd0 : pos_q;
    l3_d   = first_byte_i ? l3_offset_i : l3_q;
    ihl_s  = first_byte_i ? 6'd0 : ihl_q;
    doff_s = first_byte_i ? 7'd0 : doff_q;
    ver_s  = first_byte_i ? 3'd0 : ver_q;
    nop_s  = first_byte_i ? 7'd20 : nop_q;
    kind_s = first_byte_i ? 8'd0 : kind_q;
    olen_s = first_byte_i ? 8'd0 : olen_q;
    stop_s = first_byte_i ? 1'b0 : stop_q;
    mss_s  = first_byte_i ? 16'd0 : mss_q;
    mf_s   = first_byte_i ? 1'b0 : mf_q;
    cks_s  = first_byte_i ? 16'd0 : cks_q;
    r = p - {8'd0, l3_d};
    ihl_d = ihl_s; doff_d = doff_s; ver_d = ver_s; nop_d = nop_s; kind_d = kind_s;
    olen_d = olen_s; stop_d = stop_s; mss_d = mss_s; mf_d = mf_s; cks_d = cks_s;
    t = 16'd0; nb = 9'd0;
    if (p >= {8'd0, l3_d}) begin
      // IPv4 header fields
      if (r == 16'd0) begin
        ihl_d = {pkt_byte_i[3:0], 2'b00};
        if (pkt_byte_i[7:4] != 4'h4) ver_d[0] = 1'b1;
      end else if (r == 16'd6) begin
        if (pkt_byte_i[4:0] != 5'd0) ver_d[1] = 1'b1;
      end else if (r == 16'd7) begin
        if (pkt_byte_i != 8'd0) ver_d[1] = 1'b1;
      end else if (r == 16'd9) begin
        if (pkt_byte_i != 8'd6) ver_d[0] = 1'b1;
      end
      t = r - {10'd0, ihl_d};
      if (ihl_d >= 6'd20 && r >= {10'd0, ihl_d}) begin
        // TCP header fields
        if (t == 16'd12) doff_d = {1'b0, pkt_byte_i[7:4], 2'b00};
        else if (t == 16'd13) begin
          if (pkt_byte_i[1]) ver_d[2] = 1'b1;
        end else if (t == 16'd16) cks_d = {pkt_byte_i, cks_s[7:0]};
        else if (t == 16'd17) cks_d = {cks_s[15:8], pkt_byte_i};
        // option walk sees the data offset including this byte's update
        if (doff_d >= 7'd20 && !stop_s && t >= 16'd20) begin
          if (kind_s == 8'd0) begin
            if (t == {9'd0, nop_s}) begin
              if ({9'd0, nop_s} + 16'd1 >= {9'd0, doff_d} || pkt_byte_i == 8'd0)
                stop_d = 1'b1;
              else if (pkt_byte_i == 8'd1) nop_d = nop_s + 7'd1;
              else kind_d = pkt_byte_i;
            end
          end else if (olen_s == 8'd0) begin
            if (t == {9'd0, nop_s} + 16'd1) begin
              nb = {2'd0, nop_s} + {1'b0, pkt_byte_i};
              if (pkt_byte_i < 8'd2 || nb > {2'd0, doff_d}) stop_d = 1'b1;
              else if (kind_s == OptMss && pkt_byte_i == 8'd4) olen_d = pkt_byte_i;
              else begin
                nop_d = nb[6:0];
                kind_d = 8'd0;
              end
            end
          end else begin
            if (t == {9'd0, nop_s} + 16'd2) mss_d = {pkt_byte_i, 8'd0};
            else if (t == {9'd0, nop_s} + 16'd3) begin
              mss_d = {mss_s[15:8], pkt_byte_i};
              mf_d = 1'b1;
              stop_d = 1'b1;
            end
          end
        end
      end
    end
    pos_d = (p != 16'hFFFF) ? p + 16'd1 : p;
    sum_o.len = p + 16'd1;
    sum_o.l3 = l3_d; sum_o.ihl = ihl_d; sum_o.doff = doff_d; sum_o.verdict = ver_d;
    sum_o.opt_pos = nop_d; sum_o.mss = mss_d; sum_o.mss_found = mf_d; sum_o.cks = cks_d;
    sum_valid_o = take_i && last_byte_i;
  end

  // Packet state; cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; l3_q <= '0; ihl_q <= '0; doff_q <= '0; ver_q <= '0; nop_q <= 7'd20;
      kind_q <= '0; olen_q <= '0; stop_q <= 1'b0; mss_q <= '0; mf_q <= 1'b0; cks_q <= '0;
    end else if (take_i) begin
      l3_q <= l3_d;
      if (last_byte_i) begin
        pos_q <= '0; ihl_q <= '0; doff_q <= '0; ver_q <= '0; nop_q <= 7'd20;
        kind_q <= '0; olen_q <= '0; stop_q <= 1'b0; mss_q <= '0; mf_q <= 1'b0;
        cks_q <= '0;
      end else begin
        pos_q <= pos_d; ihl_q <= ihl_d; doff_q <= doff_d; ver_q <= ver_d;
        nop_q <= nop_d; kind_q <= kind_d; olen_q <= olen_d; stop_q <= stop_d;
        mss_q <= mss_d; mf_q <= mf_d; cks_q <= cks_d;
      end
    end
  end
endmodule

FILE: src/tsmc_queue.sv
// Two-entry queue of packet summaries between parser and finisher.
`timescale 1ns / 1ps
`include "tcp_syn_mss_clamper_defines.svh"
module tsmc_queue import tsmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pkt_sum_t data_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output pkt_sum_t data_o
);
  pkt_sum_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  `TMC_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, full_o, !push_i || pop_i)
  `TMC_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, valid_o)
  `TMC_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
endmodule

FILE: src/tsmc_finisher.sv
// Back end: status checks, MSS cap and incremental checksum.
`timescale 1ns / 1ps
`include "tcp_syn_mss_clamper_defines.svh"
module tsmc_finisher import tsmc_pkg::*; #(
  parameter int unsigned MaxPacketBytes = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        enable_i,
  input  logic [15:0] mtu_i,
  input  logic [15:0] overhead_i,
  input  logic        in_valid_i,
  input  pkt_sum_t    sum_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] old_mss_o,
  output logic [15:0] new_mss_o,
  output logic [15:0] mss_offset_o,
  output logic [15:0] new_checksum_o,
  output logic [15:0] checksum_offset_o
);
  // stage 1: checks and cap
  logic        s1_q;
  status_e     st1_q, st1_d;
  logic        mf1_q, mf1_d;
  logic [15:0] old1_q, cap1_q, cks1_q, moff1_q, coff1_q;
  logic [15:0] cap_d, moff_d, coff_d;
  logic        adv1, adv2;
  logic        out_q;
  status_e     st_q;
  logic [15:0] old_q, new_q, moff_q, nck_q, coff_q;

  logic [17:0] lim_a, lim_b, lim_c, lim_d;
  logic [17:0] capw;
  logic [8:0]  tcp_start;

  always_comb begin
    lim_a = {10'd0, sum_i.l3} + 18'd20;
    lim_b = {10'd0, sum_i.l3} + {12'd0, sum_i.ihl} + 18'd20;
    lim_c = {10'd0, sum_i.l3} + {12'd0, sum_i.ihl} + {11'd0, sum_i.doff};
    lim_d = {12'd0, sum_i.ihl} + 18'd20 + {2'd0, overhead_i};
    capw  = {2'd0, mtu_i} - lim_d;
    tcp_start = {1'b0, sum_i.l3} + {3'd0, sum_i.ihl};
    coff_d = {7'd0, tcp_start} + 16'd16;
    moff_d = {7'd0, tcp_start} + {9'd0, sum_i.opt_pos} + 16'd2;
    if (capw < MinMss) cap_d = MinMss[15:0];
    else if (capw > 18'h0FFFF) cap_d = 16'hFFFF;
    else cap_d = capw[15:0];
    mf1_d = 1'b0;
    priority if (!enable_i) st1_d = ST_NONE;
    else if ({16'd0, sum_i.len} > 32'(MaxPacketBytes) || {16'd0, mtu_i} < 32'(MinMtu) ||
             {2'd0, sum_i.len} < lim_a || sum_i.verdict[0]) st1_d = ST_ERROR;
    else if (sum_i.verdict[1]) st1_d = ST_NONE;
    else if (sum_i.ihl < 6'd20 || {2'd0, sum_i.len} < lim_b) st1_d = ST_ERROR;
    else if (!sum_i.verdict[2]) st1_d = ST_NONE;
    else if (sum_i.doff < 7'd20 || {2'd0, sum_i.len} < lim_c || {2'd0, mtu_i} <= lim_d)
      st1_d = ST_ERROR;
    else begin
      st1_d = ST_NONE;
      mf1_d = 1'b1;
    end
  end

  // mf1 marks an enabled, well-formed SYN that is eligible for clamping
  assign adv2 = !out_q || !stall_i;
  assign adv1 = !s1_q || adv2;
  assign pop_o = in_valid_i && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_q <= 1'b0;
    else if (adv1) s1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      st1_q <= st1_d; mf1_q <= mf1_d; cap1_q <= cap_d;
      old1_q <= sum_i.mss_found ? sum_i.mss : 16'd0;
      cks1_q <= sum_i.cks; coff1_q <= coff_d;
      moff1_q <= sum_i.mss_found ? moff_d : 16'd0;
    end
  end

  // stage 2: clamp decision and checksum fold
  logic [17:0] sum1;
  logic [16:0] fold;
  logic        clamp;
  always_comb begin
    clamp = mf1_q && old1_q != 16'd0 && old1_q > cap1_q;
    sum1 = {2'd0, ~cks1_q} + {2'd0, ~old1_q} + {2'd0, cap1_q};
    fold = {1'b0, sum1[15:0]} + {15'd0, sum1[17:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_q <= 1'b0;
    else if (adv2) out_q <= s1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_q) begin
      if (!mf1_q) begin
        st_q <= st1_q; old_q <= '0; new_q <= '0; moff_q <= '0; nck_q <= '0; coff_q <= '0;
      end else begin
        st_q <= clamp ? ST_CLAMPED : ST_NONE;
        old_q <= old1_q; moff_q <= moff1_q; coff_q <= coff1_q;
        new_q <= clamp ? cap1_q : old1_q;
        nck_q <= clamp ? ~(fold[15:0] + {15'd0, fold[16]}) : cks1_q;
      end
    end
  end

  assign valid_o = out_q;
  assign status_o = st_q;
  assign old_mss_o = old_q;
  assign new_mss_o = new_q;
  assign mss_offset_o = moff_q;
  assign new_checksum_o = nck_q;
  assign checksum_offset_o = coff_q;

  `TMC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_q && stall_i, out_q && $stable(st_q))
  `TMC_ASSERT_IMP(a_clamp_lower, clk_i, rst_ni, out_q && st_q == ST_CLAMPED, new_q < old_q)
  `TMC_ASSERT_IMP(a_status_legal, clk_i, rst_ni, out_q, st_q == ST_NONE || st_q == ST_CLAMPED || st_q == ST_ERROR)
endmodule

FILE: src/tcp_syn_mss_clamper.sv
// Top level of the TCP SYN MSS clamp.
// Takes one packet byte per cycle while in_stall_o is low; each last byte
// yields one result word via the summary queue, the finisher check stage
// and its checksum stage. The two-entry queue decouples the byte parser
// from the output stall, so the parser keeps taking bytes unless the queue
// is full and a last byte arrives. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module tcp_syn_mss_clamper import tsmc_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pkt_byte_i,
  input  logic [7:0]  l3_offset_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] old_mss_o,
  output logic [15:0] new_mss_o,
  output logic [15:0] mss_offset_o,
  output logic [15:0] new_checksum_o,
  output logic [15:0] checksum_offset_o
);
  logic        en_q;
  logic [15:0] mtu_q, ovh_q;
  logic        take, full, push, qv, pop;
  pkt_sum_t    sum_in, sum_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0; mtu_q <= 16'd1500; ovh_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE:   en_q <= cfg_data_i[0];
        CFG_MTU:      mtu_q <= cfg_data_i;
        CFG_OVERHEAD: ovh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full && last_byte_i;
  assign take = in_valid_i && !in_stall_o;

  tsmc_parser u_parser (
    .clk_i, .rst_ni, .take_i(take), .pkt_byte_i, .l3_offset_i, .first_byte_i,
    .last_byte_i, .sum_valid_o(push), .sum_o(sum_in)
  );

  tsmc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(sum_in), .full_o(full),
    .valid_o(qv), .pop_i(pop), .data_o(sum_out)
  );

  tsmc_finisher #(.MaxPacketBytes(MAX_PACKET_BYTES)) u_finisher (
    .clk_i, .rst_ni, .enable_i(en_q), .mtu_i(mtu_q), .overhead_i(ovh_q),
    .in_valid_i(qv), .sum_i(sum_out), .pop_o(pop), .valid_o(out_valid_o),
    .stall_i(out_stall_i), .status_o, .old_mss_o, .new_mss_o, .mss_offset_o,
    .new_checksum_o, .checksum_offset_o
  );
endmodule
